>>> rtl/sti_pkg.sv
// shared types and codes for the sorted table insert and search block
`timescale 1ns / 1ps
`default_nettype none
package sti_pkg;

	localparam int KeyW = 32;
	localparam int PosW = 6;
	localparam int FillW = 7;

	// opcode values on the input tuser
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	// result status codes on the output tuser
	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_FOUND     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic                   acc;
		logic                   wr;
		logic                   srch;
		logic signed [KeyW-1:0] key;
	} cell_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/sti_cell.sv
// one cell of the sorted key chain: holds a key, compares, shifts from its lower neighbor
`timescale 1ns / 1ps
`default_nettype none
module sti_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  wire logic                           clk,
	input  wire sti_pkg::cell_ctrl_t            ctrl,
	input  wire logic [CW-1:0]                  cnt,
	input  wire logic                           prev_le,
	input  wire logic                           prev_eq,
	input  wire logic signed [sti_pkg::KeyW-1:0] prev_key,
	output logic                                le,
	output logic                                eq,
	output logic signed [sti_pkg::KeyW-1:0]     key_out,
	output logic                                hit
);

	logic signed [sti_pkg::KeyW-1:0] key_q;
	logic                            hit_q;
	logic                            valid;
	logic                            mark;

	// compare the stored key against the broadcast key
	always_comb begin
		valid = (cnt > CW'(IDX));
		le    = valid && (key_q <= ctrl.key);
		eq    = valid && (key_q == ctrl.key);
		mark  = ctrl.srch ? (eq && !prev_eq) : (!le && prev_le);
	end

	// capture the match mark and shift or load the key on insert
	always_ff @(posedge clk) begin
		if (ctrl.acc) begin
			hit_q <= mark;
		end
		if (ctrl.acc && ctrl.wr && !le) begin
			key_q <= prev_le ? ctrl.key : prev_key;
		end
	end

	assign key_out = key_q;
	assign hit     = hit_q;

endmodule
`default_nettype wire

>>> rtl/sorted_table_insert_search.sv
// top level of the sorted key table with ordered insert and search
// For each item, in the accept cycle every cell of the chain compares
// the broadcast key, an insert shifts the larger keys up one cell, and each cell
// registers a one-hot match mark; the marks are then encoded into a position and
// the result is loaded into the output register when it is empty or being read.
// A new item is taken once the previous result has moved into the output register,
// so no item is accepted while the one before it is pending. Keys are signed
// Q16.16; equal keys are inserted after the ones already held, and a search reports
// the lowest index holding the key. An insert into a full table drops the key.
`timescale 1ns / 1ps
`default_nettype none
module sorted_table_insert_search #(
	parameter int DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // key[31:0]
	input  wire logic [0:0]  s_tuser,  // opcode[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // position[5:0], fill[12:6], zero[15:13]
	output logic [1:0]       m_tuser   // status[1:0]
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	logic [CW-1:0]        cnt_q;
	logic                 pend_q;
	logic                 op_s1;
	logic                 full_s1;
	logic                 acc;
	logic                 full;
	logic                 load;
	sti_pkg::cell_ctrl_t  ctrl;
	logic [DEPTH-1:0]     le_w;
	logic [DEPTH-1:0]     eq_w;
	logic [DEPTH-1:0]     hit_w;
	logic signed [sti_pkg::KeyW-1:0] key_w [DEPTH];
	logic [IW-1:0]        pos;
	logic                 m_tvalid_q;
	logic [15:0]          m_tdata_q;
	sti_pkg::status_t     status_q;
	sti_pkg::status_t     status;
	logic [sti_pkg::PosW-1:0] pos_out;

	// input handshake and broadcast
	assign s_tready  = !pend_q;
	assign acc       = s_tvalid && s_tready;
	assign full      = (cnt_q == CW'(DEPTH));
	assign ctrl.acc  = acc;
	assign ctrl.srch = (s_tuser[0] == sti_pkg::OP_SEARCH);
	assign ctrl.wr   = (s_tuser[0] == sti_pkg::OP_INSERT) && !full;
	assign ctrl.key  = $signed(s_tdata);

	// chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			sti_cell #(.IDX(i), .CW(CW)) u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.cnt      (cnt_q),
				.prev_le  (1'b1),
				.prev_eq  (1'b0),
				.prev_key (ctrl.key),
				.le       (le_w[i]),
				.eq       (eq_w[i]),
				.key_out  (key_w[i]),
				.hit      (hit_w[i])
			);
		end else begin : g_next
			sti_cell #(.IDX(i), .CW(CW)) u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.cnt      (cnt_q),
				.prev_le  (le_w[i-1]),
				.prev_eq  (eq_w[i-1]),
				.prev_key (key_w[i-1]),
				.le       (le_w[i]),
				.eq       (eq_w[i]),
				.key_out  (key_w[i]),
				.hit      (hit_w[i])
			);
		end
	end

	// occupancy and the pending item stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			if (acc && ctrl.wr) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (acc) begin
				pend_q <= 1'b1;
			end else if (load) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1   <= s_tuser[0];
			full_s1 <= full;
		end
	end

	// encode the one-hot match mark into an index
	always_comb begin
		pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (hit_w[i]) begin
				pos = pos | IW'(i);
			end
		end
	end

	// result status and position
	always_comb begin
		pos_out = '0;
		if (op_s1 == sti_pkg::OP_SEARCH) begin
			if (|hit_w) begin
				status  = sti_pkg::ST_FOUND;
				pos_out = sti_pkg::PosW'(pos);
			end else begin
				status = sti_pkg::ST_NOT_FOUND;
			end
		end else if (full_s1) begin
			status = sti_pkg::ST_FULL;
		end else begin
			status  = sti_pkg::ST_INSERTED;
			pos_out = sti_pkg::PosW'(pos);
		end
	end

	// output register
	assign load = pend_q && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q  <= status;
			m_tdata_q <= {3'b000, sti_pkg::FillW'(cnt_q), pos_out};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = status_q;

endmodule
`default_nettype wire

>>> rtl/sti_check.sv
// port-level checker for the sorted key table, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module sti_check #(
	parameter int DEPTH = 64
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	localparam logic [6:0] FillFull = 7'(DEPTH % 128);

	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// one item in flight: no accept right after an accept
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted while one is pending");

	// a full result reports position zero and a full count
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == sti_pkg::ST_FULL) |->
			(m_tdata[5:0] == 6'd0) && (m_tdata[12:6] == FillFull))
		else $error("full result with bad position or fill");

	// a miss reports position zero and padding stays clear
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:13] == 3'd0) &&
			((m_tuser != sti_pkg::ST_NOT_FOUND) || (m_tdata[5:0] == 6'd0)))
		else $error("miss with nonzero position or dirty padding");

endmodule

bind sorted_table_insert_search sti_check #(.DEPTH(DEPTH)) u_sti_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

>>> tb/sorted_table_checker.sv
// checker for the sorted table: predicts each result and compares it with the block
`timescale 1ns / 1ps
module sorted_table_checker #(
	parameter int DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [31:0] s_tdata,  // key[31:0]
	input  wire logic [0:0]  s_tuser,  // opcode[0]
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [15:0] m_tdata,  // position[5:0], fill[12:6], zero[15:13]
	input  wire logic [1:0]  m_tuser,  // status[1:0]
	output int               fail_count,
	output int               pending
);
	import sti_pkg::*;

	typedef struct packed {
		status_t          status;
		logic [PosW-1:0]  position;
		logic [FillW-1:0] fill;
	} outcome_t;

	// shadow copy of the table, ascending
	logic signed [KeyW-1:0] table_keys [DEPTH];
	int                     held;
	outcome_t               outcome_q [$];
	int                     errs;

	initial begin
		fail_count = 0;
		pending = 0;
		errs = 0;
		held = 0;
	end

	// apply one operation to the shadow table and give its result
	function automatic outcome_t apply_table_op(logic op, logic signed [KeyW-1:0] key);
		outcome_t o;
		int       at;
		int       i;
		o.status = ST_NOT_FOUND;
		o.position = '0;
		if (op == OP_INSERT) begin
			if (held >= DEPTH) begin
				o.status = ST_FULL;
			end else begin
				// insert point goes past every key not greater than the new one
				at = 0;
				for (i = 0; i < held; i++) begin
					if (table_keys[i] <= key) at = i + 1;
				end
				for (i = held; i > at; i--) begin
					table_keys[i] = table_keys[i - 1];
				end
				table_keys[at] = key;
				held++;
				o.status = ST_INSERTED;
				o.position = PosW'(at);
			end
		end else begin
			// scan downward so the lowest equal index wins
			for (i = held - 1; i >= 0; i--) begin
				if (table_keys[i] == key) begin
					o.status = ST_FOUND;
					o.position = PosW'(i);
				end
			end
		end
		o.fill = FillW'(held);
		return o;
	endfunction

	task automatic note_mismatch(input string what);
		errs++;
		if (errs <= 10) $display("%0t mismatch: %s", $realtime, what);
	endtask

	// result compare first, then prediction of a newly accepted item
	always @(posedge clk or negedge arst_n) begin
		outcome_t got;
		outcome_t want;
		if (!arst_n) begin
			held = 0;
			outcome_q.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status = status_t'(m_tuser);
				got.position = m_tdata[PosW-1:0];
				got.fill = m_tdata[PosW+FillW-1:PosW];
				if (outcome_q.size() == 0) begin
					note_mismatch($sformatf("unexpected result status %0d pos %0d fill %0d",
						got.status, got.position, got.fill));
				end else begin
					want = outcome_q.pop_front();
					if (got !== want) begin
						note_mismatch($sformatf(
							"status exp %0d got %0d, pos exp %0d got %0d, fill exp %0d got %0d",
							want.status, got.status, want.position, got.position,
							want.fill, got.fill));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				outcome_q.push_back(apply_table_op(s_tuser[0], $signed(s_tdata)));
			end
			pending <= outcome_q.size();
			fail_count <= errs;
		end
	end

endmodule

>>> tb/sorted_table_insert_search_test.sv
// testbench top for the sorted table: stimulus, output back-pressure and verdict
`timescale 1ns / 1ps
module sorted_table_insert_search_test;
	import sti_pkg::*;

	localparam int DEPTH = 64;
	localparam int RAND_ITEMS = 1634;
	localparam logic [31:0] KEY_MIN = 32'h8000_0000;
	localparam logic [31:0] KEY_MAX = 32'h7fff_ffff;
	localparam logic [31:0] KEY_ZERO = 32'h0000_0000;
	localparam logic [31:0] KEY_NEG1 = 32'hffff_ffff;
	localparam logic [31:0] KEY_ONE = 32'h0001_0000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	int          fail_count;
	int          pending;
	int          send_gap_pct;
	int          recv_idle_pct;
	logic [31:0] used_keys [$];

	sorted_table_insert_search #(.DEPTH(DEPTH)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	sorted_table_checker #(.DEPTH(DEPTH)) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// output back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// present one item with random gaps ahead of it, hold until taken
	task automatic send_item(input logic op, input logic [31:0] key);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= key;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op == OP_INSERT) used_keys.push_back(key);
	endtask

	// keys lean on ones already sent for insert so duplicates and hits are common
	function automatic logic [31:0] pick_key(input logic op);
		int          r;
		logic [31:0] k;
		r = $urandom_range(99);
		if (used_keys.size() > 0 && r < 60) begin
			k = used_keys[$urandom_range(used_keys.size() - 1)];
			if (op == OP_SEARCH && r >= 45) k = ($urandom_range(1) != 0) ? k + 1 : k - 1;
			return k;
		end
		if (r < 70) begin
			case ($urandom_range(4))
				0: return KEY_MIN;
				1: return KEY_MAX;
				2: return KEY_ZERO;
				3: return KEY_NEG1;
				default: return KEY_ONE;
			endcase
		end
		return $urandom();
	endfunction

	initial begin
		logic op;
		int   guard;
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_INSERT;
		send_gap_pct <= 10;
		recv_idle_pct <= 82;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, duplicates, misses next to held keys
		send_item(OP_SEARCH, KEY_ZERO);
		send_item(OP_INSERT, KEY_ZERO);
		send_item(OP_INSERT, KEY_MAX);
		send_item(OP_INSERT, KEY_MIN);
		send_item(OP_INSERT, KEY_ZERO);
		send_item(OP_SEARCH, KEY_ZERO);
		send_item(OP_SEARCH, KEY_MIN);
		send_item(OP_SEARCH, KEY_MAX);
		send_item(OP_SEARCH, KEY_NEG1);
		send_item(OP_INSERT, KEY_NEG1);
		send_item(OP_INSERT, KEY_ONE);
		send_item(OP_INSERT, KEY_MIN);
		send_item(OP_SEARCH, KEY_MIN);
		send_item(OP_INSERT, KEY_MAX);
		send_item(OP_SEARCH, KEY_MAX);
		send_item(OP_SEARCH, KEY_MAX - 1);
		send_item(OP_SEARCH, KEY_MIN + 1);

		// random: few inserts so the table fills late and then stays full
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS / 3) begin
				send_gap_pct <= 82;
				recv_idle_pct <= 10;
			end else if (n == 2 * RAND_ITEMS / 3) begin
				send_gap_pct <= 0;
				recv_idle_pct <= 0;
			end
			op = ($urandom_range(99) < 5) ? OP_INSERT : OP_SEARCH;
			send_item(op, pick_key(op));
		end
		s_tvalid <= 1'b0;

		// drain outstanding results, then idle before the verdict
		guard = 0;
		while (pending != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
